// ===== hdl/rlm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared widths, constants and handshake types of the RMS level meter.
// ----------------------------------------------------------------------------
package rlm_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int SQ_W              = 32;
   localparam int SUM_W             = 40;
   localparam int LEVEL_W           = 16;
   localparam int COUNT_OUT_W       = 10;
   localparam int RSP_DATA_W        = 32;
   localparam int RSP_PAD_W         = RSP_DATA_W - LEVEL_W - COUNT_OUT_W;
   localparam int ROOT_W            = SUM_W / 2;
   localparam int RAD_W             = ROOT_W + 2;
   localparam int DIV_STEPS         = SUM_W;
   localparam int ROOT_STEPS        = ROOT_W;
   localparam int STEP_W            = $clog2(DIV_STEPS);
   localparam int MAX_BLOCK_DEFAULT = 512;
   localparam int CNT_W_DEFAULT     = $clog2(MAX_BLOCK_DEFAULT + 1);

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
   localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

   // Request to the divide / root unit
   typedef struct packed {
      logic start;
   } unit_ctrl_type;

   // Status back from the divide / root unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage : rlm_pkg
`default_nettype wire

// ===== hdl/rms_level_meter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_level_meter_core
// Block RMS level of a stream of signed 16-bit audio samples.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one sample per item in req_tdata, req_tlast closes a block.
//   Each sample is squared and added to a saturating 40-bit sum; samples past
//   MAX_BLOCK in one block are dropped and flagged as overflow.
//   rsp channel: one item per block, floor(sqrt(floor(sum / count))) in
//   unsigned Q1.15 (32768 is full scale), the sample count, and in rsp_tuser
//   the overflow flag.
// Input flow: an item without req_tlast is accepted, then added in an
//   accumulate state in which no item is taken; the 16x16 squarer feeds
//   a single 40-bit adder. A closing item holds off the next item while
//   the result is computed, and for longer while rsp_tready stays low.
// Result path: after the closing item is accepted come accumulate, load,
//   40 divide steps and 20 root steps of the shared subtract unit, then
//   capture, which raises rsp_tvalid.
// After a closing item req_tready stays low until the result has been taken.
// Reset clears the sum, count, flag and handshakes; no result is pending.
// A stalled receiver holds the result in place and the block takes nothing.
// ----------------------------------------------------------------------------
module rms_level_meter_core #(
   parameter int MAX_BLOCK = rlm_pkg::MAX_BLOCK_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req_tdata: [15:0] sample (signed)
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [rlm_pkg::SAMPLE_W-1:0]    req_tdata,
   input  wire logic                            req_tlast,
   // rsp_tdata: [15:0] rms_level, [25:16] sample_count, [31:26] zero
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [rlm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [0] overflow
   output      logic                            rsp_tuser
);
   import rlm_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ACCUM = 5'b00010,
      S_LOAD  = 5'b00100,
      S_ROOT  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    dropped_ff, dropped_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic                    last_ff, last_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic [COUNT_OUT_W-1:0]  out_count_ff, out_count_in;
   logic                    out_over_ff, out_over_in;

   logic signed [SAMPLE_W-1:0]  sample_s;
   logic signed [SQ_W-1:0]      product;
   logic [SUM_W:0]              sum_ext;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;
   logic                        room;
   unit_ctrl_type               unit_ctrl;
   unit_stat_type               unit_stat;
   logic [ROOT_W-1:0]           unit_root;

   // Square at the port, register the product before the add
   assign sample_s = signed'(req_tdata);
   assign product  = sample_s * sample_s;
   assign sq_in    = (req_tvalid && req_tready) ? unsigned'(product) : sq_ff;
   assign last_in  = (req_tvalid && req_tready) ? req_tlast : last_ff;

   assign sum_ext   = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
   assign room      = (count_ff < CNT_W'(MAX_BLOCK));
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   assign unit_ctrl.start = (state_ff == S_LOAD);

   rlm_root_unit #(
      .CNT_W (CNT_W)
   ) u_root (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (unit_ctrl),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .stat     (unit_stat),
      .root     (unit_root)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      level_in     = level_ff;
      out_count_in = out_count_ff;
      out_over_in  = out_over_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_ACCUM;
            end
         end
         S_ACCUM: begin
            // add with saturation, or drop the sample once the block is full
            if (room) begin
               sum_in   = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
               count_in = count_ff + 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
            state_in = last_ff ? S_LOAD : S_IDLE;
         end
         S_LOAD: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (unit_stat.done) begin
               if (count_ff == '0) begin
                  level_in = '0;
               end else if (|unit_root[ROOT_W-1:LEVEL_W]) begin
                  level_in = LEVEL_MAX;
               end else begin
                  level_in = unit_root[LEVEL_W-1:0];
               end
               out_count_in = count_ext[COUNT_OUT_W-1:0];
               out_over_in  = dropped_ff;
               // clear the block state for the next block
               sum_in       = '0;
               count_in     = '0;
               dropped_in   = 1'b0;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      last_ff      <= last_in;
      level_ff     <= level_in;
      out_count_ff <= out_count_in;
      out_over_ff  <= out_over_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_count_ff, level_ff};
   assign rsp_tuser  = out_over_ff;

   // Never take a sample while a result waits
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // The root unit finishes only while the sequencer waits for it
   a_done_in_root : assert property (@(posedge clock) disable iff (reset)
      unit_stat.done |-> (state_ff == S_ROOT))
      else $error("root unit finished outside the wait state");

   // Start the root unit only when it is idle
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      unit_ctrl.start |-> !unit_stat.busy)
      else $error("root unit started while busy");

   // The count never passes the block limit
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCK))
      else $error("sample count beyond block limit");

   // Block state is clear once a result has been handed over
   a_clear_after_rsp : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> (count_ff == '0 && !dropped_ff && req_tready))
      else $error("block state not cleared after result");

endmodule : rms_level_meter_core
`default_nettype wire

// ===== hdl/rlm_root_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlm_root_unit
// Iterative floor(sqrt(floor(dividend / divisor))). One shared subtract and
// compare serves a restoring divide (one quotient bit a cycle) and then a
// digit-by-digit square root (one root bit a cycle).
// ----------------------------------------------------------------------------
module rlm_root_unit #(
   parameter int CNT_W = rlm_pkg::CNT_W_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rlm_pkg::unit_ctrl_type      ctrl,
   input  wire logic [rlm_pkg::SUM_W-1:0]   dividend,
   input  wire logic [CNT_W-1:0]            divisor,
   output      rlm_pkg::unit_stat_type      stat,
   output      logic [rlm_pkg::ROOT_W-1:0]  root
);
   import rlm_pkg::*;

   localparam int SUB_W = (CNT_W + 1 > RAD_W) ? CNT_W + 1 : RAD_W;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_DIV  = 3'b010,
      U_ROOT = 3'b100
   } ustate_type;

   ustate_type          ustate_ff, ustate_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [ROOT_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;

   logic [CNT_W:0]      div_cand;
   logic [RAD_W-1:0]    sqrt_cand;
   logic [RAD_W-1:0]    trial;
   logic [SUB_W-1:0]    op_a, op_b;
   logic [SUB_W:0]      diff;
   logic                ge;

   // Shared subtract: borrow clear means operand a is not below operand b
   assign div_cand  = {rem_ff, quo_ff[SUM_W-1]};
   assign sqrt_cand = {srem_ff, quo_ff[SUM_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      if (ustate_ff == U_DIV) begin
         op_a = SUB_W'(div_cand);
         op_b = SUB_W'(divisor);
      end else begin
         op_a = SUB_W'(sqrt_cand);
         op_b = SUB_W'(trial);
      end
   end

   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~diff[SUB_W];

   always_comb begin
      ustate_in = ustate_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      srem_in   = srem_ff;
      root_in   = root_ff;
      case (ustate_ff)
         U_IDLE: begin
            if (ctrl.start) begin
               quo_in    = dividend;
               rem_in    = '0;
               step_in   = '0;
               ustate_in = U_DIV;
            end
         end
         U_DIV: begin
            // shift in one quotient bit, keep the partial remainder
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            rem_in  = ge ? diff[CNT_W-1:0] : div_cand[CNT_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in   = '0;
               srem_in   = '0;
               root_in   = '0;
               ustate_in = U_ROOT;
            end
         end
         U_ROOT: begin
            // consume two radicand bits, produce one root bit
            quo_in  = {quo_ff[SUM_W-3:0], 2'b00};
            srem_in = ge ? diff[ROOT_W-1:0] : sqrt_cand[ROOT_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               step_in   = '0;
               done_in   = 1'b1;
               ustate_in = U_IDLE;
            end
         end
         default: begin
            ustate_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         step_ff   <= '0;
         done_ff   <= 1'b0;
      end else begin
         ustate_ff <= ustate_in;
         step_ff   <= step_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign stat.busy = (ustate_ff != U_IDLE);
   assign stat.done = done_ff;
   assign root      = root_ff;

endmodule : rlm_root_unit
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rms_level_meter_core. Sample items are driven on
// the req stream and folded into a block-level predictor. Each closing item
// queues the expected level, count and overflow flag, and every rsp item is
// compared against the oldest entry. A short table of corner samples runs
// first. Randomly sized blocks follow, under changing sender and receiver
// back-pressure, with one full block and one overrunning block among them.
// ----------------------------------------------------------------------------
module testbench;
   import rlm_pkg::*;

   localparam int BLOCK_LIMIT  = MAX_BLOCK_DEFAULT;
   localparam int PHASE_ITEMS  = 160;     // samples in random blocks per phase
   localparam int DRAIN_CYCLES = 100;     // settling wait before the final queue check
   localparam int CYCLE_LIMIT  = 600000;

   // One block result as it travels on rsp
   typedef struct packed {
      logic [LEVEL_W-1:0]     level;
      logic [COUNT_OUT_W-1:0] count;
      logic                   overflow;
   } level_result_type;

   // One row of the corner table; has_level marks a result typed in by hand
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      logic                has_level;
      level_result_type    level_res;
   } corner_row_type;

   localparam int CORNER_ROWS = 20;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   // Block accumulator of the predictor
   longint unsigned        blk_square_sum = 0;
   int unsigned            blk_count      = 0;
   bit                     blk_dropped    = 1'b0;

   level_result_type       level_q[$];
   int unsigned            send_idle_pct  = 0;
   int unsigned            recv_stall_pct = 0;
   int unsigned            error_count    = 0;
   int unsigned            cycle_count    = 0;

   // Full scale, both ends, zero, unit steps, a short mean and a few
   // constant blocks whose level reads straight off the samples.
   corner_row_type corner_tab [0:CORNER_ROWS-1] = '{
      '{16'h8000, 1'b1, 1'b1, '{16'd32768, 10'd1, 1'b0}},
      '{16'h7FFF, 1'b1, 1'b1, '{16'd32767, 10'd1, 1'b0}},
      '{16'h0000, 1'b1, 1'b1, '{16'd0,     10'd1, 1'b0}},
      '{16'h0001, 1'b1, 1'b1, '{16'd1,     10'd1, 1'b0}},
      '{16'hFFFF, 1'b1, 1'b1, '{16'd1,     10'd1, 1'b0}},
      '{16'h0003, 1'b0, 1'b0, '0},
      '{16'h0004, 1'b1, 1'b1, '{16'd3,     10'd2, 1'b0}},
      '{16'h8000, 1'b0, 1'b0, '0},
      '{16'h8000, 1'b0, 1'b0, '0},
      '{16'h8000, 1'b0, 1'b0, '0},
      '{16'h8000, 1'b1, 1'b1, '{16'd32768, 10'd4, 1'b0}},
      '{16'h7FFF, 1'b0, 1'b0, '0},
      '{16'h8000, 1'b1, 1'b0, '0},
      '{16'h0064, 1'b0, 1'b0, '0},
      '{16'hFF9C, 1'b0, 1'b0, '0},
      '{16'h0064, 1'b1, 1'b1, '{16'd100,   10'd3, 1'b0}},
      '{16'h04D2, 1'b0, 1'b0, '0},
      '{16'hE9D2, 1'b0, 1'b0, '0},
      '{16'h07FF, 1'b0, 1'b0, '0},
      '{16'h5555, 1'b1, 1'b0, '0}
   };

   rms_level_meter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Fold one sample into the block; on the closing item work out the
   // level from the integer mean and clear the block.
   function automatic bit fold_sample(input logic [SAMPLE_W-1:0] smp, input bit lst,
                                      output level_result_type res);
      longint          sv;
      longint unsigned mean;
      longint unsigned root;
      longint unsigned trial;
      res  = '0;
      sv   = longint'($signed(smp));
      if (blk_count < BLOCK_LIMIT) begin
         blk_square_sum = blk_square_sum + longint'(sv * sv);
         if (blk_square_sum > longint'(SUM_MAX))
            blk_square_sum = longint'(SUM_MAX);
         blk_count++;
      end else begin
         blk_dropped = 1'b1;
      end
      if (!lst)
         return 1'b0;
      mean = (blk_count != 0) ? blk_square_sum / blk_count : 0;
      // square root, one result bit at a time from the top
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= mean)
            root = trial;
      end
      if (root > 64'hFFFF)
         root = 64'hFFFF;
      res.level    = root[LEVEL_W-1:0];
      res.count    = blk_count[COUNT_OUT_W-1:0];
      res.overflow = blk_dropped;
      blk_square_sum = 0;
      blk_count      = 0;
      blk_dropped    = 1'b0;
      return 1'b1;
   endfunction

   // Mix of full-scale, quiet and fully random samples
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int unsigned mode;
      mode = $urandom_range(0, 9);
      case (mode)
         0: begin
            return 16'h8000;
         end
         1: begin
            return 16'h7FFF;
         end
         2: begin
            return SAMPLE_W'($urandom_range(0, 510) - 255);
         end
         3: begin
            return '0;
         end
         default: begin
            return SAMPLE_W'($urandom_range(0, 16'hFFFF));
         end
      endcase
   endfunction

   // Offer one item from a falling edge and hold it until accepted; leave
   // tvalid high on return so that it does not fall between back-to-back items.
   task automatic send_item(input logic [SAMPLE_W-1:0] smp, input bit lst,
                            input bit has_level, input level_result_type typed_res);
      level_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= SAMPLE_W'($urandom);
         req_tlast  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tlast  <= lst;
      do
         @(posedge clock);
      while (!req_tready);
      if (fold_sample(smp, lst, res))
         level_q.push_back(has_level ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic send_block(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_item(pick_sample(), i == len - 1, 1'b0, '0);
   endtask

   // Hold the sender until every block closed so far has been reported
   task automatic drain_results();
      while (level_q.size() != 0)
         @(negedge clock);
   endtask

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      level_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_q.size() == 0) begin
            $error("unexpected result: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = level_q.pop_front();
            if (rsp_tdata[LEVEL_W-1:0] !== want.level) begin
               $error("rms_level: expected %0d, actual %0d",
                      want.level, rsp_tdata[LEVEL_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[LEVEL_W +: COUNT_OUT_W] !== want.count) begin
               $error("sample_count: expected %0d, actual %0d",
                      want.count, rsp_tdata[LEVEL_W +: COUNT_OUT_W]);
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0) begin
               $error("tdata padding: expected 0, actual %h",
                      rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]);
               error_count++;
            end
            if (rsp_tuser !== want.overflow) begin
               $error("overflow: expected %b, actual %b", want.overflow, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rms_level_meter_core verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner table, no idling
      for (int i = 0; i < CORNER_ROWS; i++)
         send_item(corner_tab[i].sample, corner_tab[i].last,
                   corner_tab[i].has_level, corner_tab[i].level_res);

      // phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         // drop tvalid while the sender pauses
         req_tvalid <= 1'b0;
         drain_results();
         case (ph)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 59; recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 59;
            end
            default: begin
               send_idle_pct = 23; recv_stall_pct = 23;
            end
         endcase
         // one block filled to the limit, one run past it
         if (ph == 1)
            send_block(BLOCK_LIMIT);
         if (ph == 3)
            send_block(BLOCK_LIMIT + 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               len = $urandom_range(1, 6);
            else if (pick < 9)
               len = $urandom_range(7, 32);
            else
               len = $urandom_range(33, 100);
            send_block(len);
            sent += len;
         end
      end

      req_tvalid <= 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (level_q.size() != 0) begin
         $error("%0d results never arrived", level_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("rms_level_meter_core verification clean");
      else
         $display("rms_level_meter_core verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rlm_pkg.sv
hdl/rlm_root_unit.sv
hdl/rms_level_meter_core.sv
dv/testbench.sv
